### rtl/sorted_deadline_timer_queue_assert.svh
// Assertion macros shared by the timer queue modules.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef SORTED_DEADLINE_TIMER_QUEUE_ASSERT_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_ASSERT_SVH

// A condition that must hold at every clock edge.
`define SDTQ_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define SDTQ_CHECK_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sdtq_pkg.sv
package sdtq_pkg;

  localparam int CAPACITY  = 16;
  localparam int TIME_BITS = 64;
  localparam int NUM_IDS   = 16;
  localparam int ID_W      = 4;
  localparam int POS_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  localparam logic [1:0] KIND_INSERT  = 2'd0;
  localparam logic [1:0] KIND_REMOVE  = 2'd1;
  localparam logic [1:0] KIND_EXPIRED = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_DEL  = 2'd1,
    OP_INS  = 2'd2
  } store_op_t;

  // Request from the sequencer to the sorted store.
  typedef struct packed {
    store_op_t             op;
    logic [POS_W-1:0]      pos;
    logic [ID_W-1:0]       id;
    logic [TIME_BITS-1:0]  dl;
  } store_req_t;

  // Status of the sorted store as seen by the sequencer.
  typedef struct packed {
    logic [CNT_W-1:0]      count;
    logic [ID_W-1:0]       rd_id;
    logic [TIME_BITS-1:0]  rd_dl;
    logic [TIME_BITS-1:0]  head_dl;
    logic                  look_flag;
  } store_sts_t;

endpackage

### rtl/sdtq_store.sv
module sdtq_store
  import sdtq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  store_req_t       req,
  input  logic [ID_W-1:0]  look_id,
  output store_sts_t       sts
);

  logic [ID_W-1:0]      ids_r [CAPACITY];
  logic [TIME_BITS-1:0] dls_r [CAPACITY];
  logic [NUM_IDS-1:0]   flags_r;
  logic [CNT_W-1:0]     count_r;

  assign sts.count     = count_r;
  assign sts.rd_id     = ids_r[req.pos];
  assign sts.rd_dl     = dls_r[req.pos];
  assign sts.head_dl   = dls_r[0];
  assign sts.look_flag = flags_r[look_id];

  // Entries are kept in ascending deadline order; a delete closes the gap
  // by moving the tail down one place, an insert opens one by moving it up.
  always_ff @(posedge clk) begin
    case (req.op)
      OP_DEL: begin
        for (int j = 0; j < CAPACITY - 1; j++) begin
          if (POS_W'(j) >= req.pos) begin
            ids_r[j] <= ids_r[j+1];
            dls_r[j] <= dls_r[j+1];
          end
        end
      end
      OP_INS: begin
        for (int j = 1; j < CAPACITY; j++) begin
          if (POS_W'(j) > req.pos) begin
            ids_r[j] <= ids_r[j-1];
            dls_r[j] <= dls_r[j-1];
          end
        end
        ids_r[req.pos] <= req.id;
        dls_r[req.pos] <= req.dl;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      count_r <= '0;
    end else begin
      case (req.op)
        OP_DEL: begin
          flags_r[req.id] <= 1'b0;
          count_r         <= count_r - CNT_W'(1);
        end
        OP_INS: begin
          flags_r[req.id] <= 1'b1;
          count_r         <= count_r + CNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

`include "sorted_deadline_timer_queue_assert.svh"

  `SDTQ_CHECK(a_count_bound, count_r <= CNT_W'(CAPACITY), "queue count beyond capacity")
  `SDTQ_CHECK(a_ins_room, (req.op != OP_INS) || (count_r < CNT_W'(CAPACITY)), "insert into full queue")
  `SDTQ_CHECK(a_del_nonempty, (req.op != OP_DEL) || (count_r != '0), "delete from empty queue")

endmodule

### rtl/sdtq_ctrl.sv
module sdtq_ctrl
  import sdtq_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [1:0]   in_command,
  input  logic [3:0]   in_timer_id,
  input  logic [63:0]  in_deadline,
  input  logic [63:0]  in_current_time,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [1:0]   out_result_kind,
  output logic [3:0]   out_expired_id,
  output logic         out_was_queued,
  output logic         out_head_changed,
  output logic         out_queue_nonempty,
  output logic [63:0]  out_next_event_time,
  output logic         out_last_result,
  output store_req_t   req,
  input  store_sts_t   sts
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FIND  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_REPLY = 5'b01000,
    ST_TICK  = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [1:0]           cmd_r, cmd_nxt;
  logic [ID_W-1:0]      id_r, id_nxt;
  logic [TIME_BITS-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]     scan_r, scan_nxt;
  logic                 wq_r, wq_nxt;
  logic                 hc_r, hc_nxt;
  logic                 pend_r, pend_nxt;
  logic [ID_W-1:0]      pend_id_r, pend_id_nxt;
  logic                 out_valid_r;

  logic                 out_free;
  logic                 le;
  logic                 expire;
  logic                 emit;
  logic [1:0]           e_kind;
  logic [ID_W-1:0]      e_id;
  logic                 e_wq;
  logic                 e_hc;
  logic                 e_last;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  // The one deadline comparator: the entry at the scan position against the key.
  assign le     = (sts.rd_dl <= key_r);
  assign expire = (sts.count != '0) && le;

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    id_nxt      = id_r;
    key_nxt     = key_r;
    scan_nxt    = scan_r;
    wq_nxt      = wq_r;
    hc_nxt      = hc_r;
    pend_nxt    = pend_r;
    pend_id_nxt = pend_id_r;
    req.op      = OP_NONE;
    req.pos     = scan_r[POS_W-1:0];
    req.id      = id_r;
    req.dl      = key_r;
    emit        = 1'b0;
    e_kind      = KIND_NONE;
    e_id        = '0;
    e_wq        = 1'b0;
    e_hc        = 1'b0;
    e_last      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt  = in_command;
          id_nxt   = in_timer_id;
          scan_nxt = '0;
          pend_nxt = 1'b0;
          hc_nxt   = 1'b0;
          wq_nxt   = sts.look_flag;
          case (in_command)
            CMD_INSERT: begin
              key_nxt = in_deadline[TIME_BITS-1:0];
              if (sts.look_flag) begin
                state_nxt = ST_FIND;
              end else if (sts.count >= CNT_W'(CAPACITY)) begin
                state_nxt = ST_REPLY;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            CMD_REMOVE: begin
              state_nxt = sts.look_flag ? ST_FIND : ST_REPLY;
            end
            CMD_TICK: begin
              key_nxt   = in_current_time[TIME_BITS-1:0];
              state_nxt = ST_TICK;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FIND: begin
        if (sts.rd_id == id_r) begin
          req.op    = OP_DEL;
          scan_nxt  = '0;
          state_nxt = (cmd_r == CMD_INSERT) ? ST_SCAN : ST_REPLY;
        end else begin
          scan_nxt = scan_r + CNT_W'(1);
        end
      end
      ST_SCAN: begin
        // Equal deadlines stay ahead, so the scan passes over them.
        if ((scan_r < sts.count) && le) begin
          scan_nxt = scan_r + CNT_W'(1);
        end else begin
          req.op    = OP_INS;
          hc_nxt    = (scan_r == '0);
          state_nxt = ST_REPLY;
        end
      end
      ST_REPLY: begin
        if (out_free) begin
          emit      = 1'b1;
          e_kind    = (cmd_r == CMD_INSERT) ? KIND_INSERT : KIND_REMOVE;
          e_wq      = wq_r;
          e_hc      = hc_r;
          state_nxt = ST_IDLE;
        end
      end
      ST_TICK: begin
        // A popped timer is held back until the new head has been compared,
        // so that its word can say whether it is the last.
        req.id = sts.rd_id;
        if (pend_r) begin
          if (out_free) begin
            emit   = 1'b1;
            e_kind = KIND_EXPIRED;
            e_id   = pend_id_r;
            e_last = !expire;
            if (expire) begin
              req.op      = OP_DEL;
              pend_id_nxt = sts.rd_id;
            end else begin
              pend_nxt  = 1'b0;
              state_nxt = ST_IDLE;
            end
          end
        end else if (expire) begin
          req.op      = OP_DEL;
          pend_nxt    = 1'b1;
          pend_id_nxt = sts.rd_id;
        end else if (out_free) begin
          emit      = 1'b1;
          e_kind    = KIND_NONE;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      if (out_free) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    id_r      <= id_nxt;
    key_r     <= key_nxt;
    scan_r    <= scan_nxt;
    wq_r      <= wq_nxt;
    hc_r      <= hc_nxt;
    pend_id_r <= pend_id_nxt;
    // The queue is sampled before any change made in the same cycle.
    if (out_free && emit) begin
      out_result_kind     <= e_kind;
      out_expired_id      <= e_id;
      out_was_queued      <= e_wq;
      out_head_changed    <= e_hc;
      out_last_result     <= e_last;
      out_queue_nonempty  <= (sts.count != '0);
      out_next_event_time <= 64'((sts.count != '0) ? sts.head_dl : '0);
    end
  end

`include "sorted_deadline_timer_queue_assert.svh"

  `SDTQ_CHECK_NEXT(a_cmd_starts, in_valid && !in_stall && (in_command != CMD_NOP), state_r != ST_IDLE, "accepted command did not start")
  `SDTQ_CHECK(a_find_range, (state_r != ST_FIND) || (scan_r < sts.count), "id search ran past the queue")
  `SDTQ_CHECK(a_scan_room, (state_r != ST_SCAN) || (sts.count < CNT_W'(CAPACITY)), "insert scan with full queue")

endmodule

### rtl/sorted_deadline_timer_queue.sv
// Sorted deadline timer queue: holds up to CAPACITY timers, one per 4-bit id, in ascending
// deadline order, with equal deadlines kept in arrival order. Words are handled one at a
// time by a small sequencer around a single deadline comparator that walks the sorted
// entries one per cycle; in_stall is high from acceptance until the last result has been
// loaded into the output register. The id search and the insertion-point scan each look at
// one entry a cycle, and a tick pops its expired timers one at a time. Results wait in the
// output register while out_stall is high, which holds the sequencer but never drops
// a result.
module sorted_deadline_timer_queue
  import sdtq_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [1:0]   in_command,
  input  logic [3:0]   in_timer_id,
  input  logic [63:0]  in_deadline,
  input  logic [63:0]  in_current_time,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [1:0]   out_result_kind,
  output logic [3:0]   out_expired_id,
  output logic         out_was_queued,
  output logic         out_head_changed,
  output logic         out_queue_nonempty,
  output logic [63:0]  out_next_event_time,
  output logic         out_last_result
);

  store_req_t req;
  store_sts_t sts;

  sdtq_ctrl u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_timer_id         (in_timer_id),
    .in_deadline         (in_deadline),
    .in_current_time     (in_current_time),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result_kind     (out_result_kind),
    .out_expired_id      (out_expired_id),
    .out_was_queued      (out_was_queued),
    .out_head_changed    (out_head_changed),
    .out_queue_nonempty  (out_queue_nonempty),
    .out_next_event_time (out_next_event_time),
    .out_last_result     (out_last_result),
    .req                 (req),
    .sts                 (sts)
  );

  sdtq_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .look_id (in_timer_id),
    .sts     (sts)
  );

endmodule

### verif/tb_top.sv
module tb_top;
  import sdtq_pkg::*;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  timer_id;
    logic [63:0] deadline;
    logic [63:0] current_time;
    logic        drain;
  } timer_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  expired_id;
    logic        was_queued;
    logic        head_changed;
    logic        nonempty;
    logic [63:0] next_time;
    logic        last;
  } timer_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = CMD_NOP;
  logic [3:0]  in_timer_id = 4'd0;
  logic [63:0] in_deadline = 64'd0;
  logic [63:0] in_current_time = 64'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_result_kind;
  logic [3:0]  out_expired_id;
  logic        out_was_queued;
  logic        out_head_changed;
  logic        out_queue_nonempty;
  logic [63:0] out_next_event_time;
  logic        out_last_result;

  sorted_deadline_timer_queue dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_timer_id         (in_timer_id),
    .in_deadline         (in_deadline),
    .in_current_time     (in_current_time),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result_kind     (out_result_kind),
    .out_expired_id      (out_expired_id),
    .out_was_queued      (out_was_queued),
    .out_head_changed    (out_head_changed),
    .out_queue_nonempty  (out_queue_nonempty),
    .out_next_event_time (out_next_event_time),
    .out_last_result     (out_last_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the timer queue.
  logic [63:0] timer_deadline [NUM_IDS];
  logic        timer_armed    [NUM_IDS];
  logic [3:0]  timer_order    [CAPACITY];
  int          timers_queued;

  timer_word_t   pending_words[$];
  timer_result_t timer_results_due[$];
  timer_word_t   current_word;
  int            results_pushed = 0;
  int            results_seen = 0;
  int            rx_count = 0;
  int            error_count = 0;
  int            tx_gap = 0;
  int            rx_wait = 0;
  bit            tx_burst = 1'b0;
  bit            rx_burst = 1'b0;
  bit            tx_busy;

  task automatic report_mismatch(input string what);
    if (error_count < 40)
      $display("mismatch at %0t: %s", $time, what);
    error_count++;
  endtask

  function automatic int idle_cycles(input bit burst);
    return burst ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic logic [63:0] random_time();
    return {$urandom, $urandom};
  endfunction

  function automatic void clear_timer_queue();
    int i;
    for (i = 0; i < NUM_IDS; i++)
      timer_armed[i] = 1'b0;
    timers_queued = 0;
  endfunction

  function automatic bit unlink_timer(input logic [3:0] id);
    int  i;
    bit  found;
    found = 1'b0;
    if (!timer_armed[id])
      return 1'b0;
    for (i = 0; i < timers_queued; i++) begin
      if (!found && timer_order[i] == id)
        found = 1'b1;
      if (found && i + 1 < timers_queued)
        timer_order[i] = timer_order[i + 1];
    end
    timers_queued--;
    timer_armed[id] = 1'b0;
    return 1'b1;
  endfunction

  function automatic void push_timer_result(input logic [1:0] kind, input logic [3:0] id,
                                            input logic wq, input logic hc, input logic last);
    timer_result_t r;
    r.kind         = kind;
    r.expired_id   = id;
    r.was_queued   = wq;
    r.head_changed = hc;
    r.nonempty     = (timers_queued != 0);
    r.next_time    = (timers_queued != 0) ? timer_deadline[timer_order[0]] : 64'd0;
    r.last         = last;
    timer_results_due.push_back(r);
    results_pushed++;
  endfunction

  function automatic void apply_timer_command(input timer_word_t w);
    int         p;
    int         k;
    bit         wq;
    logic [3:0] h;
    case (w.command)
      CMD_INSERT: begin
        if (!timer_armed[w.timer_id] && timers_queued >= CAPACITY) begin
          push_timer_result(KIND_INSERT, 4'd0, 1'b0, 1'b0, 1'b1);
        end else begin
          wq = unlink_timer(w.timer_id);
          p = 0;
          while (p < timers_queued && timer_deadline[timer_order[p]] <= w.deadline)
            p++;
          for (k = timers_queued; k > p; k--)
            timer_order[k] = timer_order[k - 1];
          timer_order[p] = w.timer_id;
          timer_deadline[w.timer_id] = w.deadline;
          timer_armed[w.timer_id] = 1'b1;
          timers_queued++;
          push_timer_result(KIND_INSERT, 4'd0, wq, p == 0, 1'b1);
        end
      end
      CMD_REMOVE: begin
        wq = unlink_timer(w.timer_id);
        push_timer_result(KIND_REMOVE, 4'd0, wq, 1'b0, 1'b1);
      end
      CMD_TICK: begin
        k = 0;
        while (timers_queued != 0 && timer_deadline[timer_order[0]] <= w.current_time) begin
          h = timer_order[0];
          void'(unlink_timer(h));
          push_timer_result(KIND_EXPIRED, h, 1'b0, 1'b0,
                            timers_queued == 0 ||
                            timer_deadline[timer_order[0]] > w.current_time);
          k++;
        end
        if (k == 0)
          push_timer_result(KIND_NONE, 4'd0, 1'b0, 1'b0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  task automatic check_timer_result();
    timer_result_t want;
    if (timer_results_due.size() == 0) begin
      report_mismatch("result word with no expectation waiting");
      return;
    end
    want = timer_results_due.pop_front();
    if (out_result_kind !== want.kind)
      report_mismatch($sformatf("result_kind %0d, expected %0d", out_result_kind, want.kind));
    if (out_expired_id !== want.expired_id)
      report_mismatch($sformatf("expired_id %0d, expected %0d", out_expired_id,
                                want.expired_id));
    if (out_was_queued !== want.was_queued)
      report_mismatch($sformatf("was_queued %b, expected %b", out_was_queued,
                                want.was_queued));
    if (out_head_changed !== want.head_changed)
      report_mismatch($sformatf("head_changed %b, expected %b", out_head_changed,
                                want.head_changed));
    if (out_queue_nonempty !== want.nonempty)
      report_mismatch($sformatf("queue_nonempty %b, expected %b", out_queue_nonempty,
                                want.nonempty));
    if (out_next_event_time !== want.next_time)
      report_mismatch($sformatf("next_event_time %h, expected %h", out_next_event_time,
                                want.next_time));
    if (out_last_result !== want.last)
      report_mismatch($sformatf("last_result %b, expected %b", out_last_result, want.last));
  endtask

  // Sender: a word is held until taken, then the next follows after a drawn gap.
  // A word marked for draining is only offered once every expected result is in.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      clear_timer_queue();
    end else begin
      tx_busy = in_valid;
      if (in_valid && !in_stall) begin
        apply_timer_command(current_word);
        tx_busy = 1'b0;
        if ($urandom_range(0, 15) == 0)
          tx_burst = !tx_burst;
        tx_gap = idle_cycles(tx_burst);
      end
      if (!tx_busy) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0 &&
                     (!pending_words[0].drain || results_seen == results_pushed)) begin
          current_word = pending_words.pop_front();
          in_command      <= current_word.command;
          in_timer_id     <= current_word.timer_id;
          in_deadline     <= current_word.deadline;
          in_current_time <= current_word.current_time;
          in_valid        <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stalls for a drawn number of cycles after each word, and twice
  // holds off for a long stretch so that the block backs up into its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_timer_result();
        results_seen <= results_seen + 1;
        rx_count++;
        if ($urandom_range(0, 15) == 0)
          rx_burst = !rx_burst;
        rx_wait = idle_cycles(rx_burst);
        if (rx_count == 30 || rx_count == 150)
          rx_wait = 300;
      end
      out_stall <= (rx_wait != 0);
      if (rx_wait != 0)
        rx_wait--;
    end
  end

  function automatic void add_word(input logic [1:0] cmd, input logic [3:0] id,
                                   input logic [63:0] dl, input logic [63:0] now,
                                   input logic drain);
    timer_word_t w;
    w.command      = cmd;
    w.timer_id     = id;
    w.deadline     = dl;
    w.current_time = now;
    w.drain        = drain;
    pending_words.push_back(w);
  endfunction

  initial begin : stimulus
    int          i;
    int          n;
    int          sel;
    logic        drain;
    logic [63:0] time_base;

    // Directed part: empty queue, unknown command, extremes, ties, full queue.
    add_word(CMD_TICK, 4'd0, 64'd0, 64'd0, 1'b0);
    add_word(CMD_REMOVE, 4'd5, '1, '1, 1'b0);
    add_word(CMD_NOP, 4'd9, random_time(), random_time(), 1'b0);
    add_word(CMD_INSERT, 4'd0, '1, 64'd0, 1'b0);
    add_word(CMD_INSERT, 4'd15, 64'd0, '1, 1'b0);
    add_word(CMD_INSERT, 4'd7, 64'd0, random_time(), 1'b0);
    add_word(CMD_REMOVE, 4'd7, random_time(), random_time(), 1'b0);
    add_word(CMD_TICK, 4'd3, '1, 64'd0, 1'b0);
    for (i = 1; i < NUM_IDS; i++)
      add_word(CMD_INSERT, 4'(i), 64'($urandom_range(0, 3)) * 64'd1000, random_time(), 1'b0);
    // With every id queued, an insert can only be a re-arm.
    add_word(CMD_INSERT, 4'd3, '1, random_time(), 1'b0);
    add_word(CMD_TICK, 4'd0, random_time(), '1, 1'b0);

    // Random part: deadlines cluster around a slowly advancing time so that
    // ticks pop a few timers at once, with some wild values mixed in.
    time_base = random_time();
    n = 0;
    while (n < 185) begin
      sel = $urandom_range(0, 99);
      drain = (n % 60 == 0);
      if (sel < 45) begin
        add_word(CMD_INSERT, 4'($urandom_range(0, 15)),
                 time_base + 64'($urandom_range(0, 400)), random_time(), drain);
      end else if (sel < 65) begin
        add_word(CMD_REMOVE, 4'($urandom_range(0, 15)), random_time(), random_time(), drain);
      end else if (sel < 90) begin
        time_base = time_base + 64'($urandom_range(0, 150));
        add_word(CMD_TICK, 4'($urandom_range(0, 15)), random_time(), time_base, drain);
      end else if (sel < 93) begin
        add_word(CMD_INSERT, 4'($urandom_range(0, 15)), random_time(), random_time(), drain);
      end else if (sel < 96) begin
        add_word(CMD_TICK, 4'($urandom_range(0, 15)), random_time(), random_time(), drain);
      end else begin
        add_word(CMD_NOP, 4'($urandom_range(0, 15)), random_time(), random_time(), 1'b0);
        n--;
      end
      n++;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_valid)
      @(posedge clk);
    while (results_seen != results_pushed)
      @(posedge clk);
    repeat (60) @(posedge clk);
    if (timer_results_due.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                timer_results_due.size()));
    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin : watchdog
    #2500000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/sdtq_pkg.sv
rtl/sdtq_store.sv
rtl/sdtq_ctrl.sv
rtl/sorted_deadline_timer_queue.sv
verif/tb_top.sv
